// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL, included by the slot engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/rbse_pkg.sv =====
// Shared widths, codes and parameter defaults of the broadcast slot engine.
package rbse_pkg;

   localparam int SLOTS_DEFAULT       = 512;
   localparam int MAX_WORKERS_DEFAULT = 8;

   localparam int MODE_W   = 2;
   localparam int SEQ_W    = 32;
   localparam int SLOT_W   = 9;
   localparam int WORKER_W = 3;
   localparam int COUNT_W  = 4;
   localparam int KIND_W   = 2;
   localparam int CSR_DATA_W = 4;
   localparam int CSR_IDX_W  = 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_DATA = 2'd0,
      MODE_ACK  = 2'd1,
      MODE_TICK = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA = 2'd0,
      KIND_ACK  = 2'd1,
      KIND_NAK  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROOT_RANK    = 1'b0,
      CSR_WORKER_COUNT = 1'b1
   } csr_index_type;

endpackage

// ===== hw/rtl/rbse_req_if.sv =====
// Request channel: incoming packets and retransmit ticks.
interface rbse_req_if;
   logic                                valid;
   logic                                ready;
   logic [rbse_pkg::MODE_W-1:0]         mode;
   logic [rbse_pkg::SEQ_W-1:0]          seq_num;
   logic [rbse_pkg::SLOT_W-1:0]         slot_index;
   logic [rbse_pkg::WORKER_W-1:0]       source_worker;

   modport source (output valid, output mode, output seq_num, output slot_index,
                   output source_worker, input ready);
   modport sink (input valid, input mode, input seq_num, input slot_index,
                 input source_worker, output ready);
endinterface

// ===== hw/rtl/rbse_rsp_if.sv =====
// Response channel: outgoing data, ack and nak packets.
interface rbse_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rbse_pkg::KIND_W-1:0]         out_kind;
   logic [rbse_pkg::WORKER_W-1:0]       dest_worker;
   logic [rbse_pkg::SEQ_W-1:0]          out_seq_num;
   logic [rbse_pkg::SLOT_W-1:0]         out_slot;
   logic                                last;

   modport source (output valid, output out_kind, output dest_worker, output out_seq_num,
                   output out_slot, output last, input ready);
   modport sink (input valid, input out_kind, input dest_worker, input out_seq_num,
                 input out_slot, input last, output ready);
endinterface

// ===== hw/rtl/reliable_broadcast_slot_engine.sv =====
// Top level of the switch-side reliable broadcast slot engine.
//
// After reset the engine runs a clearing pass that writes every slot entry
// (expected number = slot index, empty, no acks); no item is taken during it,
// configuration writes are. Then one item at a time: on acceptance its slot
// entry is read from the single-port slot memory, and in ST_READ it is decided
// and, if changed, written back. Each result then leaves through the output
// register; an item yields up to 1 + number of children results, and the sink
// can stall them. root_rank and worker_count must only be written while idle.
`include "assert_macros.svh"

module reliable_broadcast_slot_engine #(
   parameter int SLOTS       = rbse_pkg::SLOTS_DEFAULT,
   parameter int MAX_WORKERS = rbse_pkg::MAX_WORKERS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rbse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rbse_pkg::CSR_DATA_W-1:0]     csr_wdata,
   rbse_req_if.sink                            req_if,
   rbse_rsp_if.source                          rsp_if
);

   localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CHILD_W = MAX_WORKERS;
   localparam int CNT_W   = $clog2(MAX_WORKERS + 1);
   localparam int WL      = (MAX_WORKERS < 16) ? MAX_WORKERS : 16;
   localparam int WID_W   = $clog2(WL);
   localparam int SEQ_W   = rbse_pkg::SEQ_W;
   localparam int ACK_LO  = CNT_W;
   localparam int FULL_B  = CNT_W + CHILD_W;
   localparam int SEQ_LO  = FULL_B + 1;
   localparam int ENT_W   = SEQ_LO + SEQ_W;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [rbse_pkg::WORKER_W-1:0] root_ff, root_in;
   logic [rbse_pkg::COUNT_W-1:0]  wcount_ff, wcount_in;

   // clearing pass
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // latched item
   logic [rbse_pkg::MODE_W-1:0]   item_mode_ff, item_mode_in;
   logic [SEQ_W-1:0]              item_seq_ff, item_seq_in;
   logic [rbse_pkg::SLOT_W-1:0]   item_slot_ff, item_slot_in;
   logic [rbse_pkg::WORKER_W-1:0] item_src_ff, item_src_in;

   // emission state
   logic                          pend_ff, pend_in;
   logic [rbse_pkg::KIND_W-1:0]   pend_kind_ff, pend_kind_in;
   logic [SEQ_W-1:0]              pend_seq_ff, pend_seq_in;
   logic [WL-1:0]                 mask_ff, mask_in;
   logic [SEQ_W-1:0]              data_seq_ff, data_seq_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rbse_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [rbse_pkg::WORKER_W-1:0] rsp_dest_ff, rsp_dest_in;
   logic [SEQ_W-1:0]              rsp_seq_ff, rsp_seq_in;
   logic [rbse_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                          rsp_last_ff, rsp_last_in;

   // slot memory
   logic             ram_en, ram_we;
   logic [AW-1:0]    ram_addr;
   logic [ENT_W-1:0] ram_wdata, ram_rdata;

   rbse_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // entry fields as read
   logic [CNT_W-1:0]   rd_cnt;
   logic [CHILD_W-1:0] rd_acked;
   logic               rd_full;
   logic [SEQ_W-1:0]   rd_seq;

   assign rd_cnt   = ram_rdata[CNT_W-1:0];
   assign rd_acked = ram_rdata[ACK_LO +: CHILD_W];
   assign rd_full  = ram_rdata[FULL_B];
   assign rd_seq   = ram_rdata[SEQ_LO +: SEQ_W];

   logic req_fire;
   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   // ---------------- slot decision ----------------
   logic [rbse_pkg::COUNT_W-1:0]  wc_use;
   logic [rbse_pkg::COUNT_W-1:0]  child_total;
   logic                          src_ok, src_is_root, slot_ok;
   logic                          seq_lt, seq_gt, seq_eq;
   logic [rbse_pkg::WORKER_W-1:0] ack_pos;
   logic [CHILD_W-1:0]            pos_hot;
   logic [CHILD_W:0]              acked_up;
   logic [WL-1:0]                 send_all, send_unacked;
   logic [CNT_W-1:0]              cnt_inc;

   logic                          dec_wb;
   logic [ENT_W-1:0]              dec_entry;
   logic                          dec_pend;
   logic [rbse_pkg::KIND_W-1:0]   dec_kind;
   logic [SEQ_W-1:0]              dec_seq;
   logic [WL-1:0]                 dec_mask;

   always_comb begin
      wc_use = (32'(wcount_ff) > 32'(MAX_WORKERS)) ? rbse_pkg::COUNT_W'(MAX_WORKERS)
                                                    : wcount_ff;
      child_total = ({1'b0, root_ff} < wc_use) ? (wc_use - 4'd1) : wc_use;
      src_ok      = ({1'b0, item_src_ff} < wc_use);
      src_is_root = (item_src_ff == root_ff);
      slot_ok     = ({23'd0, item_slot_ff} < 32'(SLOTS));
      seq_lt      = (item_seq_ff < rd_seq);
      seq_gt      = (item_seq_ff > rd_seq);
      seq_eq      = (item_seq_ff == rd_seq);
      ack_pos     = (root_ff < item_src_ff) ? (item_src_ff - 3'd1) : item_src_ff;
      cnt_inc     = rd_cnt + CNT_W'(1);
      acked_up    = {rd_acked, 1'b0};

      for (int k = 0; k < CHILD_W; k++) begin
         pos_hot[k] = (32'(ack_pos) == k);
      end

      // child position of worker w is w, or w-1 past the root
      for (int w = 0; w < WL; w++) begin
         send_all[w] = (32'(wc_use) > w) && (32'(root_ff) != w);
         send_unacked[w] = send_all[w] &&
                           !((32'(root_ff) < w) ? acked_up[w] : acked_up[w + 1]);
      end
   end

   always_comb begin
      dec_wb    = 1'b0;
      dec_entry = ram_rdata;
      dec_pend  = 1'b0;
      dec_kind  = rbse_pkg::KIND_ACK;
      dec_seq   = item_seq_ff;
      dec_mask  = '0;

      if (slot_ok) begin
         unique case (item_mode_ff)
            rbse_pkg::MODE_DATA: begin
               if (src_ok && src_is_root) begin
                  if (seq_lt) begin
                     dec_pend = 1'b1;
                  end else if (seq_gt) begin
                     if (rd_full) begin
                        dec_mask = send_unacked;
                     end else begin
                        dec_pend = 1'b1;
                        dec_kind = rbse_pkg::KIND_NAK;
                        dec_seq  = rd_seq;
                     end
                  end else if (rd_full) begin
                     dec_pend = 1'b1;
                  end else begin
                     // first copy: store, ack root, fan out to all children
                     dec_wb    = 1'b1;
                     dec_entry = {rd_seq, 1'b1, {CHILD_W{1'b0}}, {CNT_W{1'b0}}};
                     dec_pend  = 1'b1;
                     dec_mask  = send_all;
                  end
               end
            end
            rbse_pkg::MODE_ACK: begin
               if (src_ok && !src_is_root && seq_eq && ((rd_acked & pos_hot) == '0)) begin
                  dec_wb = 1'b1;
                  if (8'(cnt_inc) == 8'(child_total)) begin
                     dec_entry = {rd_seq + 32'(SLOTS), 1'b0, {CHILD_W{1'b0}},
                                  {CNT_W{1'b0}}};
                  end else begin
                     dec_entry = {rd_seq, rd_full, rd_acked | pos_hot, cnt_inc};
                  end
               end
            end
            rbse_pkg::MODE_TICK: begin
               if (rd_full) begin
                  dec_mask = send_unacked;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- result emission ----------------
   logic             emit_fire;
   logic [WID_W-1:0] low_idx;
   logic [WL-1:0]    low_hot;
   logic [WL-1:0]    mask_rest;
   logic             emit_last;

   always_comb begin
      low_idx = '0;
      for (int i = WL - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = WID_W'(i);
         end
      end
      for (int i = 0; i < WL; i++) begin
         low_hot[i] = (32'(low_idx) == i);
      end
      mask_rest = mask_ff & ~low_hot;
      emit_last = pend_ff ? (mask_ff == '0) : (mask_rest == '0);
      emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_if.ready);
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in     = state_ff;
      root_in      = root_ff;
      wcount_in    = wcount_ff;
      clr_addr_in  = clr_addr_ff;
      item_mode_in = item_mode_ff;
      item_seq_in  = item_seq_ff;
      item_slot_in = item_slot_ff;
      item_src_in  = item_src_ff;
      pend_in      = pend_ff;
      pend_kind_in = pend_kind_ff;
      pend_seq_in  = pend_seq_ff;
      mask_in      = mask_ff;
      data_seq_in  = data_seq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dest_in  = rsp_dest_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      ram_en       = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = AW'(item_slot_ff);
      ram_wdata    = dec_entry;

      if (csr_we) begin
         unique case (csr_index)
            rbse_pkg::CSR_ROOT_RANK:    root_in   = csr_wdata[rbse_pkg::WORKER_W-1:0];
            rbse_pkg::CSR_WORKER_COUNT: wcount_in = csr_wdata;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_addr_ff;
            ram_wdata = {SEQ_W'(clr_addr_ff), 1'b0, {CHILD_W{1'b0}}, {CNT_W{1'b0}}};
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               ram_en       = 1'b1;
               ram_addr     = AW'(req_if.slot_index);
               item_mode_in = req_if.mode;
               item_seq_in  = req_if.seq_num;
               item_slot_in = req_if.slot_index;
               item_src_in  = req_if.source_worker;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            ram_en       = dec_wb;
            ram_we       = dec_wb;
            pend_in      = dec_pend;
            pend_kind_in = dec_kind;
            pend_seq_in  = dec_seq;
            mask_in      = dec_mask;
            data_seq_in  = rd_seq;
            state_in     = (dec_pend || (dec_mask != '0)) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = item_slot_ff;
               rsp_last_in  = emit_last;
               if (pend_ff) begin
                  rsp_kind_in = pend_kind_ff;
                  rsp_dest_in = root_ff;
                  rsp_seq_in  = pend_seq_ff;
                  pend_in     = 1'b0;
               end else begin
                  rsp_kind_in = rbse_pkg::KIND_DATA;
                  rsp_dest_in = rbse_pkg::WORKER_W'(low_idx);
                  rsp_seq_in  = data_seq_ff;
                  mask_in     = mask_rest;
               end
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         root_ff      <= '0;
         wcount_ff    <= rbse_pkg::COUNT_W'(8);
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         wcount_ff    <= wcount_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_mode_ff <= item_mode_in;
      item_seq_ff  <= item_seq_in;
      item_slot_ff <= item_slot_in;
      item_src_ff  <= item_src_in;
      pend_kind_ff <= pend_kind_in;
      pend_seq_ff  <= pend_seq_in;
      data_seq_ff  <= data_seq_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_kind    = rsp_kind_ff;
   assign rsp_if.dest_worker = rsp_dest_ff;
   assign rsp_if.out_seq_num = rsp_seq_ff;
   assign rsp_if.out_slot    = rsp_slot_ff;
   assign rsp_if.last        = rsp_last_ff;

   // ---------------- assertions ----------------
   `ASSERT_NEXT(a_accept_reads, req_fire, state_ff == ST_READ)
   `ASSERT_IMPLIES(a_emit_has_work, state_ff == ST_EMIT, pend_ff || (mask_ff != '0))
   `ASSERT_NEXT(a_last_ends_item, emit_fire && emit_last, state_ff == ST_IDLE && rsp_valid_ff)
   `ASSERT_IMPLIES(a_write_when_owned, ram_we, state_ff == ST_CLEAR || state_ff == ST_READ)

endmodule

// ===== hw/rtl/rbse_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module rbse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== tb/sv/reliable_broadcast_slot_engine_tb.sv =====
// Self-checking testbench for the reliable broadcast slot engine.
module reliable_broadcast_slot_engine_tb;

   localparam int SLOTS       = rbse_pkg::SLOTS_DEFAULT;
   localparam int MAX_WORKERS = rbse_pkg::MAX_WORKERS_DEFAULT;
   localparam int MODE_W      = rbse_pkg::MODE_W;
   localparam int SEQ_W       = rbse_pkg::SEQ_W;
   localparam int SLOT_W      = rbse_pkg::SLOT_W;
   localparam int WORKER_W    = rbse_pkg::WORKER_W;
   localparam int COUNT_W     = rbse_pkg::COUNT_W;
   localparam int CSR_DATA_W  = rbse_pkg::CSR_DATA_W;
   localparam int IDLE_PCT    = 35;
   localparam int TAIL_CYCLES = 12;
   localparam int IDLE_LIMIT  = 5000;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [SEQ_W-1:0]    seq;
      logic [SLOT_W-1:0]   slot;
      logic [WORKER_W-1:0] src;
   } pkt_type;

   typedef struct packed {
      rbse_pkg::kind_type  kind;
      logic [WORKER_W-1:0] dest;
      logic [SEQ_W-1:0]    seq;
      logic [SLOT_W-1:0]   slot;
      logic                last;
   } rsp_type;

   // fixed: expectation typed in below (yields says whether there is one)
   typedef struct packed {
      pkt_type pkt;
      logic    fixed;
      logic    yields;
      rsp_type rsp;
   } row_type;

   localparam rsp_type NO_RSP = '0;

   // Reset settings: root 0, eight workers, slot s expects number s.
   localparam row_type SCRIPT [24] = '{
      '{'{rbse_pkg::MODE_DATA, 32'd0,         9'd0,   3'd0}, 1'b0, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_TICK, 32'd0,         9'd0,   3'd0}, 1'b0, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_DATA, 32'd0,         9'd0,   3'd0}, 1'b1, 1'b1,
        '{rbse_pkg::KIND_ACK, 3'd0, 32'd0, 9'd0, 1'b1}},
      '{'{rbse_pkg::MODE_DATA, 32'd0,         9'd511, 3'd0}, 1'b1, 1'b1,
        '{rbse_pkg::KIND_ACK, 3'd0, 32'd0, 9'd511, 1'b1}},
      '{'{rbse_pkg::MODE_DATA, 32'hFFFF_FFFF, 9'd3,   3'd0}, 1'b1, 1'b1,
        '{rbse_pkg::KIND_NAK, 3'd0, 32'd3, 9'd3, 1'b1}},
      '{'{rbse_pkg::MODE_DATA, 32'hFFFF_FFFF, 9'd0,   3'd0}, 1'b0, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd0,         9'd0,   3'd1}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd0,         9'd0,   3'd1}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd5,         9'd0,   3'd2}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd0,         9'd0,   3'd0}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_DATA, 32'd0,         9'd0,   3'd3}, 1'b1, 1'b0, NO_RSP},
      '{'{MODE_UNUSED,         32'd0,         9'd0,   3'd0}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_TICK, 32'd0,         9'd7,   3'd0}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_TICK, 32'hFFFF_FFFF, 9'd0,   3'd7}, 1'b0, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd0,         9'd0,   3'd2}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd0,         9'd0,   3'd3}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd0,         9'd0,   3'd4}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd0,         9'd0,   3'd5}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd0,         9'd0,   3'd6}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd0,         9'd0,   3'd7}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_DATA, 32'd512,       9'd0,   3'd0}, 1'b0, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_ACK,  32'd5,         9'd5,   3'd7}, 1'b1, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_DATA, 32'd511,       9'd511, 3'd0}, 1'b0, 1'b0, NO_RSP},
      '{'{rbse_pkg::MODE_DATA, 32'd0,         9'd0,   3'd0}, 1'b1, 1'b1,
        '{rbse_pkg::KIND_ACK, 3'd0, 32'd0, 9'd0, 1'b1}}
   };

   localparam logic [WORKER_W-1:0] PHASE_ROOT [8] =
      '{3'd3, 3'd7, 3'd5, 3'd0, 3'd2, 3'd6, 3'd1, 3'd4};
   localparam logic [COUNT_W-1:0] PHASE_WORKERS [8] =
      '{4'd8, 4'd15, 4'd4, 4'd1, 4'd2, 4'd0, 4'd9, 4'd8};
   localparam int PHASE_ITEMS [8] = '{60, 60, 60, 60, 60, 15, 60, 75};

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   rbse_pkg::csr_index_type csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   rbse_req_if req_if ();
   rbse_rsp_if rsp_if ();

   reliable_broadcast_slot_engine dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   always #5 clock = ~clock;

   // Engine image: settings and per-slot state.
   logic [WORKER_W-1:0] cfg_root    = '0;
   logic [COUNT_W-1:0]  cfg_workers = 4'd8;
   logic [SEQ_W-1:0]    next_seq    [SLOTS];
   logic                slot_loaded [SLOTS];
   logic [7:0]          acked_mask  [SLOTS];
   int unsigned         ack_tally   [SLOTS];

   rsp_type outgoing [$];
   rsp_type awaited  [$];
   logic [SLOT_W-1:0] hot_slots [4];

   bit quiet;
   int errors, items_sent, results_checked, stores_seen, slots_done, settings_used;
   int stuck_cycles;

   function automatic int unsigned workers_in_use();
      return (cfg_workers > MAX_WORKERS) ? MAX_WORKERS : cfg_workers;
   endfunction

   function automatic int unsigned child_count();
      return (cfg_root < workers_in_use()) ? workers_in_use() - 1 : workers_in_use();
   endfunction

   function automatic void emit(rbse_pkg::kind_type kind, logic [WORKER_W-1:0] dest,
                                logic [SEQ_W-1:0] seq, logic [SLOT_W-1:0] slot);
      rsp_type r;
      r = '{kind, dest, seq, slot, 1'b0};
      outgoing.insert(outgoing.size(), r);
   endfunction

   // One data packet per child whose bit in mask is clear, ascending id.
   function automatic void fan_out(logic [SLOT_W-1:0] slot, logic [7:0] mask);
      int unsigned pos;
      pos = 0;
      for (int unsigned w = 0; w < workers_in_use(); w++) begin
         if (w != cfg_root) begin
            if (!mask[pos]) emit(rbse_pkg::KIND_DATA, 3'(w), next_seq[slot], slot);
            pos++;
         end
      end
   endfunction

   function automatic void relay_packet(pkt_type p);
      int unsigned pos;
      outgoing.delete();
      case (p.mode)
         rbse_pkg::MODE_DATA: begin
            if (p.src < workers_in_use() && p.src == cfg_root) begin
               if (p.seq < next_seq[p.slot]) begin
                  emit(rbse_pkg::KIND_ACK, cfg_root, p.seq, p.slot);
               end else if (p.seq > next_seq[p.slot]) begin
                  if (!slot_loaded[p.slot])
                     emit(rbse_pkg::KIND_NAK, cfg_root, next_seq[p.slot], p.slot);
                  else fan_out(p.slot, acked_mask[p.slot]);
               end else if (slot_loaded[p.slot]) begin
                  emit(rbse_pkg::KIND_ACK, cfg_root, p.seq, p.slot);
               end else begin
                  slot_loaded[p.slot] = 1'b1;
                  acked_mask[p.slot]  = '0;
                  ack_tally[p.slot]   = 0;
                  stores_seen++;
                  emit(rbse_pkg::KIND_ACK, cfg_root, p.seq, p.slot);
                  fan_out(p.slot, '0);
               end
            end
         end
         rbse_pkg::MODE_ACK: begin
            if (p.src < workers_in_use() && p.src != cfg_root && p.seq == next_seq[p.slot]) begin
               pos = (cfg_root < p.src) ? p.src - 1 : p.src;
               if (!acked_mask[p.slot][pos]) begin
                  acked_mask[p.slot][pos] = 1'b1;
                  ack_tally[p.slot]++;
                  // last child in: advance by the pool size and free the slot
                  if (ack_tally[p.slot] == child_count()) begin
                     next_seq[p.slot]    = next_seq[p.slot] + SLOTS;
                     slot_loaded[p.slot] = 1'b0;
                     acked_mask[p.slot]  = '0;
                     ack_tally[p.slot]   = 0;
                     slots_done++;
                  end
               end
            end
         end
         rbse_pkg::MODE_TICK: begin
            if (slot_loaded[p.slot]) fan_out(p.slot, acked_mask[p.slot]);
         end
         default: ;
      endcase
      if (outgoing.size() > 0) outgoing[outgoing.size() - 1].last = 1'b1;
   endfunction

   // Mostly well-formed traffic on a few busy slots, some noise.
   function automatic pkt_type pick_packet();
      pkt_type p;
      int unsigned roll;
      logic [SLOT_W-1:0] s;
      logic [SEQ_W-1:0] cur;
      logic [WORKER_W-1:0] kids [$];
      for (int unsigned w = 0; w < workers_in_use(); w++)
         if (w != cfg_root) kids.insert(kids.size(), 3'(w));
      s = ($urandom_range(99) < 85) ? hot_slots[$urandom_range(3)] : 9'($urandom);
      cur = next_seq[s];
      p = '{rbse_pkg::MODE_DATA, cur, s, cfg_root};
      roll = $urandom_range(99);
      if (roll < 30) begin
         p.mode = rbse_pkg::MODE_DATA;
      end else if (roll < 62) begin
         p.mode = rbse_pkg::MODE_ACK;
         p.src = (kids.size() > 0) ? kids[$urandom_range(kids.size() - 1)] : 3'($urandom);
      end else if (roll < 70) begin
         p.mode = rbse_pkg::MODE_TICK;
         p.seq = $urandom;
      end else if (roll < 77) begin
         p.seq = (cur == 0) ? $urandom : $urandom % cur;
      end else if (roll < 85) begin
         p.seq = (cur == 32'hFFFF_FFFF) ? $urandom : cur + 1 + ($urandom % (32'hFFFF_FFFF - cur));
      end else begin
         p.mode = 2'($urandom);
         p.src = 3'($urandom);
         p.seq = $urandom_range(1) ? cur : $urandom;
      end
      return p;
   endfunction

   task automatic send_packet(pkt_type p, logic fixed, logic yields, rsp_type rsp);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.mode          <= p.mode;
      req_if.seq_num       <= p.seq;
      req_if.slot_index    <= p.slot;
      req_if.source_worker <= p.src;
      do @(posedge clock); while (!req_if.ready);
      relay_packet(p);
      if (fixed) begin
         if (yields) awaited.insert(awaited.size(), rsp);
      end else begin
         foreach (outgoing[i]) awaited.insert(awaited.size(), outgoing[i]);
      end
      items_sent++;
   endtask

   task automatic write_reg(rbse_pkg::csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == rbse_pkg::CSR_ROOT_RANK) cfg_root = value[WORKER_W-1:0];
      else cfg_workers = value;
      @(posedge clock);
   endtask

   task automatic drain();
      while (awaited.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   // Output side: random back-pressure and checking.
   initial begin
      rsp_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (awaited.size() == 0) begin
               $error("unexpected item: kind %0d dest %0d seq 0x%0h slot %0d",
                      rsp_if.out_kind, rsp_if.dest_worker, rsp_if.out_seq_num, rsp_if.out_slot);
               errors++;
            end else begin
               want = awaited.pop_front();
               check_field("out_kind", 32'(want.kind), 32'(rsp_if.out_kind));
               check_field("dest_worker", 32'(want.dest), 32'(rsp_if.dest_worker));
               check_field("out_seq_num", want.seq, rsp_if.out_seq_num);
               check_field("out_slot", 32'(want.slot), 32'(rsp_if.out_slot));
               check_field("last", 32'(want.last), 32'(rsp_if.last));
               results_checked++;
            end
         end
         rsp_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: no item moving on either side for too long.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles <= 0;
      end else if (!reset) begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= IDLE_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d items outstanding",
                     IDLE_LIMIT, awaited.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         next_seq[s]    = s;
         slot_loaded[s] = 1'b0;
         acked_mask[s]  = '0;
         ack_tally[s]   = 0;
      end
      stuck_cycles = 0;
      quiet = 1'b0;
      settings_used = 1;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= rbse_pkg::CSR_ROOT_RANK;
      csr_wdata            <= '0;
      req_if.valid         <= 1'b0;
      req_if.mode          <= rbse_pkg::MODE_DATA;
      req_if.seq_num       <= '0;
      req_if.slot_index    <= '0;
      req_if.source_worker <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part runs under the reset settings
      for (int i = 0; i < $size(SCRIPT); i++)
         send_packet(SCRIPT[i].pkt, SCRIPT[i].fixed, SCRIPT[i].yields, SCRIPT[i].rsp);
      req_if.valid <= 1'b0;
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(rbse_pkg::CSR_ROOT_RANK, {1'($urandom_range(1)), PHASE_ROOT[ph]});
         write_reg(rbse_pkg::CSR_WORKER_COUNT, PHASE_WORKERS[ph]);
         settings_used++;
         hot_slots = '{9'd0, 9'd511, 9'($urandom), 9'($urandom)};
         quiet = (ph == 6);
         for (int i = 0; i < PHASE_ITEMS[ph]; i++) send_packet(pick_packet(), 1'b0, 1'b0, NO_RSP);
         req_if.valid <= 1'b0;
         drain();
      end
      quiet = 1'b0;

      $display("Covered %0d packets under %0d engine settings; %0d outgoing packets compared.",
               items_sent, settings_used, results_checked);
      $display("Slots stored %0d times and completed %0d times.", stores_seen, slots_done);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rbse_pkg.sv
hw/rtl/rbse_req_if.sv
hw/rtl/rbse_rsp_if.sv
hw/rtl/rbse_ram.sv
hw/rtl/reliable_broadcast_slot_engine.sv
tb/sv/reliable_broadcast_slot_engine_tb.sv
